// File: src/text_console_cursor_engine_defines.svh
// Assertion macros shared by the console cursor engine checker.
// Depends on nothing; the macros expect clk and rst_n in the using scope.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console cursor engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console cursor engine check failed");

`endif

// File: src/tcce_pkg.sv
// Shared types, constants and helpers of the console cursor engine.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package tcce_pkg;

    // Fixed field widths
    localparam int CODE_W        = 8;
    localparam int CFG_COORD_W   = 12;
    localparam int CFG_SIZE_W    = 8;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 12;
    localparam int LIMIT_W       = 14;   // signed bottom-row limit, covers -255..4094
    localparam int CMD_FIXED_W   = 11;   // kind + glyph index + last

    localparam int COORD_WIDTH_DEF = 12;
    localparam int QUEUE_DEPTH     = 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CORNER_X     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CORNER_Y     = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH  = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_CODE   = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_CODE    = 8'd7;

    // Character codes
    localparam logic [CODE_W-1:0] CODE_MASK = 8'hff;
    localparam logic [CODE_W-1:0] CTRL_MASK = 8'h1f;
    localparam logic [CODE_W-1:0] CHAR_BS   = 8'h08;
    localparam logic [CODE_W-1:0] CHAR_LF   = 8'h0a;
    localparam logic [CODE_W-1:0] CHAR_FF   = 8'h0c;
    localparam logic [CODE_W-1:0] CHAR_CR   = 8'h0d;
    localparam logic [CODE_W-1:0] CHAR_BEL  = 8'h47 & CTRL_MASK;   // ctrl-G
    localparam logic [CODE_W-1:0] CHAR_VT   = 8'h4b & CTRL_MASK;   // ctrl-K
    localparam logic [CODE_W-1:0] CHAR_SUB  = 8'h5a & CTRL_MASK;   // ctrl-Z

    typedef enum logic [1:0] {
        KIND_DRAW   = 2'd0,
        KIND_BELL   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_SCROLL = 2'd3
    } cmd_kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DRAW,
        OP_ADVANCE,
        OP_RETURN,
        OP_BACK,
        OP_DOWN,
        OP_UP,
        OP_BELL,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] glyph;
    } item_t;

    typedef struct packed {
        logic [CFG_COORD_W-1:0] origin_x;
        logic [CFG_COORD_W-1:0] origin_y;
        logic [CFG_COORD_W-1:0] corner_x;
        logic [CFG_COORD_W-1:0] corner_y;
        logic [CFG_SIZE_W-1:0]  glyph_width;
        logic [CFG_SIZE_W-1:0]  glyph_height;
        logic [CODE_W-1:0]      first_code;
        logic [CODE_W-1:0]      last_code;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        origin_x:     12'd0,
        origin_y:     12'd0,
        corner_x:     12'd1152,
        corner_y:     12'd900,
        glyph_width:  8'd8,
        glyph_height: 8'd16,
        first_code:   8'd32,
        last_code:    8'd126
    };

    typedef struct packed {
        logic                      valid;
        logic signed [LIMIT_W-1:0] value;
    } limit_t;

    // A cell size of zero behaves as one.
    function automatic logic [CFG_SIZE_W-1:0] eff_size(input logic [CFG_SIZE_W-1:0] v);
        eff_size = (v == '0) ? CFG_SIZE_W'(1) : v;
    endfunction

endpackage

// File: src/text_console_cursor_engine.sv
// Console cursor engine: turns a character stream into drawing commands.
// Depends on tcce_pkg, tcce_front, tcce_fifo, tcce_limit and tcce_back.
//
// One character beat is taken whenever push is high and full is low; its
// commands (draw glyph, bell, clear screen, scroll) appear one per beat on
// the result side, oldest first, while empty is low, and leave on pop. The
// last flag marks the final command of each character (a character that
// only moves the cursor yields none unless it scrolls). The front stage
// classifies the code against the glyph range and parks it in a two-entry
// operation queue; the back sequencer then steps through take, move, wrap,
// row check and emit for each character, emits a second command if there
// is one, and stalls in emit while the two-entry result queue is full. The
// bottom-row limit needs the text area height (corner_y minus origin_y)
// modulo the cell height; a serial remainder unit derives it one bit a
// cycle, so after reset and after every register write the back end waits
// for the limit before it executes characters (they still queue up).
// Registers are written over the cfg channel, which is always ready, and
// must only be written while no character is in flight.
`timescale 1ns / 1ps

module text_console_cursor_engine #(
    parameter int COORD_WIDTH = tcce_pkg::COORD_WIDTH_DEF    // 8..16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // character input
    input  logic                                 push,
    output logic                                 full,
    input  logic [tcce_pkg::CODE_W-1:0]          char_code,
    // command output
    output logic                                 empty,
    input  logic                                 pop,
    output logic [1:0]                           cmd_kind,
    output logic [tcce_pkg::CODE_W-1:0]          glyph_index,
    output logic [COORD_WIDTH-1:0]               pos_x,
    output logic [COORD_WIDTH-1:0]               pos_y,
    output logic                                 last,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tcce_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CMD_W  = 2 * COORD_WIDTH + tcce_pkg::CMD_FIXED_W;
    localparam int ITEM_W = $bits(tcce_pkg::item_t);
    localparam int SZ     = tcce_pkg::CFG_SIZE_W;

    tcce_pkg::cfg_t     cfg_reg;
    logic               cfg_write;
    tcce_pkg::limit_t   limit;

    logic               q_push;
    logic               q_full;
    tcce_pkg::item_t    q_item_in;
    logic [ITEM_W-1:0]  q_item_out;
    logic               q_empty;
    logic               q_pop;

    logic               out_push;
    logic               out_full;
    logic [CMD_W-1:0]   out_data;
    logic [CMD_W-1:0]   res_data;

    // Register file; writes beyond the list fall through the default arm.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tcce_pkg::CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tcce_pkg::REG_ORIGIN_X:     cfg_reg.origin_x     <= cfg_data;
                tcce_pkg::REG_ORIGIN_Y:     cfg_reg.origin_y     <= cfg_data;
                tcce_pkg::REG_CORNER_X:     cfg_reg.corner_x     <= cfg_data;
                tcce_pkg::REG_CORNER_Y:     cfg_reg.corner_y     <= cfg_data;
                tcce_pkg::REG_GLYPH_WIDTH:  cfg_reg.glyph_width  <= cfg_data[SZ-1:0];
                tcce_pkg::REG_GLYPH_HEIGHT: cfg_reg.glyph_height <= cfg_data[SZ-1:0];
                tcce_pkg::REG_FIRST_CODE:   cfg_reg.first_code   <= cfg_data[SZ-1:0];
                tcce_pkg::REG_LAST_CODE:    cfg_reg.last_code    <= cfg_data[SZ-1:0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Front: take and classify characters.
    tcce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .char_code (char_code),
        .full      (full),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item_in)
    );

    // Operation queue between front and back.
    tcce_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (tcce_pkg::QUEUE_DEPTH)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (q_push),
        .din   (q_item_in),
        .full  (q_full),
        .rd_en (q_pop),
        .dout  (q_item_out),
        .empty (q_empty)
    );

    // Bottom-row limit, recomputed whenever the registers change.
    tcce_limit u_limit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_write (cfg_write),
        .limit     (limit)
    );

    // Back: cursor arithmetic and command emission.
    tcce_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .limit      (limit),
        .item_empty (q_empty),
        .item       (tcce_pkg::item_t'(q_item_out)),
        .item_pop   (q_pop),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_data   (out_data)
    );

    // Result queue: a finished command waits here; the back stalls while it is full.
    tcce_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (tcce_pkg::QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (out_push),
        .din   (out_data),
        .full  (out_full),
        .rd_en (pop),
        .dout  (res_data),
        .empty (empty)
    );

    // Command beat layout: kind, glyph index, x, y, last.
    assign cmd_kind    = res_data[CMD_W-1 -: 2];
    assign glyph_index = res_data[CMD_W-3 -: tcce_pkg::CODE_W];
    assign pos_x       = res_data[2*COORD_WIDTH : COORD_WIDTH+1];
    assign pos_y       = res_data[COORD_WIDTH : 1];
    assign last        = res_data[0];

endmodule

// File: src/tcce_fifo.sv
// Small synchronous queue used between front and back and for results.
// Depends on tcce_pkg for its default depth.
`timescale 1ns / 1ps

module tcce_fifo #(
    parameter int WIDTH = $bits(tcce_pkg::item_t),
    parameter int DEPTH = tcce_pkg::QUEUE_DEPTH    // power of two, at least 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             wr;
    logic             rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr    = wr_en && !full;
    assign rd    = rd_en && !empty;
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            unique case ({wr, rd})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: src/tcce_front.sv
// Front end: accepts character beats and classifies them into operations.
// Depends on tcce_pkg; feeds the operation queue.
`timescale 1ns / 1ps

module tcce_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcce_pkg::cfg_t                cfg,
    input  logic                          push,
    input  logic [tcce_pkg::CODE_W-1:0]   char_code,
    output logic                          full,
    input  logic                          q_full,
    output logic                          q_push,
    output tcce_pkg::item_t               q_item
);

    logic                  stage_valid_reg;
    tcce_pkg::item_t       stage_item_reg;
    tcce_pkg::item_t       item;
    logic [tcce_pkg::CODE_W-1:0] ch;
    logic                  accept;

    assign ch = char_code & tcce_pkg::CODE_MASK;

    // A code inside the glyph range always draws, even if it is a control code.
    always_comb
    begin
        item.glyph = '0;
        item.op    = tcce_pkg::OP_NONE;
        if (cfg.first_code <= ch && ch <= cfg.last_code)
        begin
            item.op    = tcce_pkg::OP_DRAW;
            item.glyph = ch - cfg.first_code;
        end
        else
        begin
            unique case (ch)
                tcce_pkg::CHAR_FF:  item.op = tcce_pkg::OP_ADVANCE;
                tcce_pkg::CHAR_CR:  item.op = tcce_pkg::OP_RETURN;
                tcce_pkg::CHAR_BS:  item.op = tcce_pkg::OP_BACK;
                tcce_pkg::CHAR_LF:  item.op = tcce_pkg::OP_DOWN;
                tcce_pkg::CHAR_BEL: item.op = tcce_pkg::OP_BELL;
                tcce_pkg::CHAR_VT:  item.op = tcce_pkg::OP_UP;
                tcce_pkg::CHAR_SUB: item.op = tcce_pkg::OP_CLEAR;
                default:            item.op = tcce_pkg::OP_NONE;
            endcase
        end
    end

    assign full   = stage_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = stage_valid_reg && !q_full;
    assign q_item = stage_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            stage_item_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
                stage_item_reg  <= item;
            end
            else if (q_push)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: src/tcce_limit.sv
// Bottom-row limit unit: corner_y - (span mod h) - h, one remainder bit a cycle.
// Depends on tcce_pkg; restarts after reset and after every register write.
`timescale 1ns / 1ps

module tcce_limit (
    input  logic              clk,
    input  logic              rst_n,
    input  tcce_pkg::cfg_t    cfg,
    input  logic              cfg_write,
    output tcce_pkg::limit_t  limit
);

    localparam int SPAN_BITS = tcce_pkg::CFG_COORD_W;
    localparam int CNT_W     = $clog2(SPAN_BITS);
    localparam int SZ        = tcce_pkg::CFG_SIZE_W;
    localparam int LW        = tcce_pkg::LIMIT_W;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_FINISH,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [SPAN_BITS-1:0] span_reg;
    logic [SZ-1:0]        rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SPAN_BITS-1:0] span;
    logic [SZ-1:0]        h;
    logic [SZ:0]          rem_shift;
    logic [SZ-1:0]        rem_step;

    // Inverted area counts as zero span.
    assign span = (cfg.corner_y >= cfg.origin_y) ? (cfg.corner_y - cfg.origin_y) : '0;
    assign h    = tcce_pkg::eff_size(cfg.glyph_height);

    assign rem_shift = {rem_reg, span_reg[SPAN_BITS-1]};
    assign rem_step  = (rem_shift >= {1'b0, h}) ? SZ'(rem_shift - {1'b0, h})
                                                : rem_shift[SZ-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            span_reg    <= '0;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            limit.valid <= 1'b0;
            limit.value <= '0;
        end
        else if (cfg_write)
        begin
            state_reg   <= ST_LOAD;
            limit.valid <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    span_reg  <= span;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    rem_reg  <= rem_step;
                    span_reg <= {span_reg[SPAN_BITS-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(SPAN_BITS - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    limit.value <= $signed(LW'(cfg.corner_y)) - $signed(LW'(rem_reg))
                                   - $signed(LW'(h));
                    limit.valid <= 1'b1;
                    state_reg   <= ST_DONE;
                end
                ST_DONE:
                begin
                    state_reg <= ST_DONE;
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

// File: src/tcce_back.sv
// Back end: carries out one operation, moves the cursor, emits commands.
// Depends on tcce_pkg; reads the operation queue, writes the result queue.
`timescale 1ns / 1ps

module tcce_back #(
    parameter int COORD_WIDTH = tcce_pkg::COORD_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  tcce_pkg::cfg_t                            cfg,
    input  tcce_pkg::limit_t                          limit,
    input  logic                                      item_empty,
    input  tcce_pkg::item_t                           item,
    output logic                                      item_pop,
    input  logic                                      out_full,
    output logic                                      out_push,
    output logic [2*COORD_WIDTH+tcce_pkg::CMD_FIXED_W-1:0] out_data
);

    localparam int CW = COORD_WIDTH;
    localparam int SW = ((CW > tcce_pkg::CFG_COORD_W) ? CW : tcce_pkg::CFG_COORD_W) + 2;
    localparam logic signed [SW-1:0] COORD_MAX = $signed(SW'({CW{1'b1}}));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE,
        ST_WRAP,
        ST_ROW,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    tcce_pkg::item_t                 item_reg;
    logic [CW-1:0]                   cursor_x_reg;
    logic [CW-1:0]                   cursor_y_reg;
    logic signed [SW-1:0]            x_reg;
    logic signed [SW-1:0]            y_reg;
    logic                            cmd1_pending_reg;
    tcce_pkg::cmd_kind_t             cmd1_kind_reg;
    logic [tcce_pkg::CODE_W-1:0]     cmd1_glyph_reg;
    logic [CW-1:0]                   cmd1_x_reg;
    logic [CW-1:0]                   cmd1_y_reg;
    logic                            scroll_reg;

    logic signed [SW-1:0] ox_s, oy_s, cx_s, cy_s, w_s, h_s, lim_s;
    logic signed [SW-1:0] cur_x_s, cur_y_s;
    logic signed [SW-1:0] row_y;
    logic                 row_scroll;

    function automatic logic [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
        if (v < 0)
        begin
            sat_coord = '0;
        end
        else if (v > COORD_MAX)
        begin
            sat_coord = '1;
        end
        else
        begin
            sat_coord = v[CW-1:0];
        end
    endfunction

    assign ox_s    = $signed(SW'(cfg.origin_x));
    assign oy_s    = $signed(SW'(cfg.origin_y));
    assign cx_s    = $signed(SW'(cfg.corner_x));
    assign cy_s    = $signed(SW'(cfg.corner_y));
    assign w_s     = $signed(SW'(tcce_pkg::eff_size(cfg.glyph_width)));
    assign h_s     = $signed(SW'(tcce_pkg::eff_size(cfg.glyph_height)));
    assign lim_s   = SW'(limit.value);
    assign cur_x_s = $signed(SW'(cursor_x_reg));
    assign cur_y_s = $signed(SW'(cursor_y_reg));

    always_comb
    begin
        row_y      = y_reg;
        row_scroll = 1'b0;
        if (y_reg < oy_s)
        begin
            row_y = oy_s;
        end
        else if (y_reg > lim_s)
        begin
            row_y      = y_reg - h_s;
            row_scroll = 1'b1;
        end
    end

    assign item_pop = (state_reg == ST_IDLE) && !item_empty && limit.valid;

    always_comb
    begin
        out_push = 1'b0;
        out_data = {cmd1_kind_reg, cmd1_glyph_reg, cmd1_x_reg, cmd1_y_reg, !scroll_reg};
        if (state_reg == ST_EMIT && !out_full)
        begin
            if (cmd1_pending_reg)
            begin
                out_push = 1'b1;
            end
            else if (scroll_reg)
            begin
                out_push = 1'b1;
                out_data = {tcce_pkg::KIND_SCROLL, tcce_pkg::CODE_W'(0), sat_coord(ox_s),
                            sat_coord(cy_s - h_s), 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            item_reg         <= '0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            cmd1_pending_reg <= 1'b0;
            cmd1_kind_reg    <= tcce_pkg::KIND_DRAW;
            cmd1_glyph_reg   <= '0;
            cmd1_x_reg       <= '0;
            cmd1_y_reg       <= '0;
            scroll_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_pop)
                    begin
                        item_reg  <= item;
                        state_reg <= ST_MOVE;
                    end
                end
                ST_MOVE:
                begin
                    x_reg            <= cur_x_s;
                    y_reg            <= cur_y_s;
                    cmd1_pending_reg <= 1'b0;
                    cmd1_glyph_reg   <= '0;
                    cmd1_x_reg       <= '0;
                    cmd1_y_reg       <= '0;
                    scroll_reg       <= 1'b0;
                    unique case (item_reg.op)
                        tcce_pkg::OP_DRAW:
                        begin
                            cmd1_pending_reg <= 1'b1;
                            cmd1_kind_reg    <= tcce_pkg::KIND_DRAW;
                            cmd1_glyph_reg   <= item_reg.glyph;
                            cmd1_x_reg       <= cursor_x_reg;
                            cmd1_y_reg       <= cursor_y_reg;
                            x_reg            <= cur_x_s + w_s;
                        end
                        tcce_pkg::OP_ADVANCE: x_reg <= cur_x_s + w_s;
                        tcce_pkg::OP_RETURN:  x_reg <= ox_s;
                        tcce_pkg::OP_BACK:    x_reg <= cur_x_s - w_s;
                        tcce_pkg::OP_DOWN:    y_reg <= cur_y_s + h_s;
                        tcce_pkg::OP_UP:      y_reg <= cur_y_s - h_s;
                        tcce_pkg::OP_BELL:
                        begin
                            cmd1_pending_reg <= 1'b1;
                            cmd1_kind_reg    <= tcce_pkg::KIND_BELL;
                        end
                        tcce_pkg::OP_CLEAR:
                        begin
                            cmd1_pending_reg <= 1'b1;
                            cmd1_kind_reg    <= tcce_pkg::KIND_CLEAR;
                            x_reg            <= ox_s;
                            y_reg            <= oy_s;
                        end
                        default:
                        begin
                            x_reg <= cur_x_s;
                        end
                    endcase
                    state_reg <= ST_WRAP;
                end
                ST_WRAP:
                begin
                    // Left clamp, or wrap to the next line at the right edge.
                    priority if (x_reg < ox_s)
                    begin
                        x_reg <= ox_s;
                    end
                    else if (x_reg >= cx_s)
                    begin
                        x_reg <= ox_s;
                        y_reg <= y_reg + h_s;
                    end
                    else
                    begin
                        x_reg <= x_reg;
                    end
                    state_reg <= ST_ROW;
                end
                ST_ROW:
                begin
                    cursor_x_reg <= sat_coord(x_reg);
                    cursor_y_reg <= sat_coord(row_y);
                    scroll_reg   <= row_scroll;
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    priority if (cmd1_pending_reg)
                    begin
                        if (!out_full)
                        begin
                            cmd1_pending_reg <= 1'b0;
                            if (!scroll_reg)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                    else if (scroll_reg)
                    begin
                        if (!out_full)
                        begin
                            scroll_reg <= 1'b0;
                            state_reg  <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/tcce_checker.sv
// Port-level checks of the console cursor engine, bound to the top level.
// Depends on tcce_pkg and text_console_cursor_engine_defines.svh.
`timescale 1ns / 1ps
`include "text_console_cursor_engine_defines.svh"

module tcce_checker #(
    parameter int COORD_WIDTH = tcce_pkg::COORD_WIDTH_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             push,
    input logic                             full,
    input logic [tcce_pkg::CODE_W-1:0]      char_code,
    input logic                             empty,
    input logic                             pop,
    input logic [1:0]                       cmd_kind,
    input logic [tcce_pkg::CODE_W-1:0]      glyph_index,
    input logic [COORD_WIDTH-1:0]           pos_x,
    input logic [COORD_WIDTH-1:0]           pos_y,
    input logic                             last,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [tcce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic is_scroll;
    logic is_draw;
    logic is_bell_or_clear;
    logic unused_inputs;

    assign is_scroll        = (cmd_kind == tcce_pkg::KIND_SCROLL);
    assign is_draw          = (cmd_kind == tcce_pkg::KIND_DRAW);
    assign is_bell_or_clear = (cmd_kind == tcce_pkg::KIND_BELL) ||
                              (cmd_kind == tcce_pkg::KIND_CLEAR);
    assign unused_inputs    = push ^ full ^ (^char_code) ^ cfg_valid ^ cfg_ready ^
                              (^cfg_index) ^ (^cfg_data);

    // A scroll always closes its character's commands.
    `TCCE_ASSERT_NOW(a_scroll_is_last, !empty && is_scroll, last)

    // Only draw commands carry a glyph number.
    `TCCE_ASSERT_NOW(a_glyph_only_on_draw, !empty && !is_draw, glyph_index == '0)

    // Bell and clear carry no position.
    `TCCE_ASSERT_NOW(a_bell_clear_at_zero, !empty && is_bell_or_clear,
                     pos_x == '0 && pos_y == '0)

    // A waiting command keeps its kind, x position and last flag until it is taken.
    `TCCE_ASSERT_NEXT(a_result_holds, !empty && !pop,
                      !empty && $stable(cmd_kind) && $stable(pos_x) && $stable(last))

endmodule

bind text_console_cursor_engine tcce_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .empty       (empty),
    .pop         (pop),
    .cmd_kind    (cmd_kind),
    .glyph_index (glyph_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
);
